/* rtl/core/kmsp_pkg.sv */
// shared types, constants and symbol table for the k-mer symbol packer
`default_nettype none

package kmsp_pkg;

  localparam int CODE_WIDTH = 16;
  localparam int SYM_W      = 16;
  localparam int RES_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [SYM_W-1:0] UNMAPPED = {SYM_W{1'b1}};

  // register indexes on the config channel
  localparam logic [CFG_IDX_W-1:0] REG_ALPHABET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYM_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BPS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 3'd4;

  // alphabet codes
  localparam logic [1:0] ALPHA_DNA     = 2'd0;
  localparam logic [1:0] ALPHA_DICE    = 2'd1;
  localparam logic [1:0] ALPHA_PROTEIN = 2'd2;
  localparam logic [1:0] ALPHA_ALNUM   = 2'd3;

  // character codes
  localparam logic [7:0] CH_UC_A = 8'h41;
  localparam logic [7:0] CH_UC_C = 8'h43;
  localparam logic [7:0] CH_UC_G = 8'h47;
  localparam logic [7:0] CH_UC_N = 8'h4E;
  localparam logic [7:0] CH_UC_T = 8'h54;
  localparam logic [7:0] CH_LC_N = 8'h6E;
  localparam logic [7:0] CH_LC_A = 8'h61;
  localparam logic [7:0] CH_LC_B = 8'h62;
  localparam logic [7:0] CH_LC_J = 8'h6A;
  localparam logic [7:0] CH_LC_O = 8'h6F;
  localparam logic [7:0] CH_LC_U = 8'h75;
  localparam logic [7:0] CH_LC_Y = 8'h79;
  localparam logic [7:0] CH_LC_Z = 8'h7A;
  localparam logic [7:0] CH_D0   = 8'h30;
  localparam logic [7:0] CH_D1   = 8'h31;
  localparam logic [7:0] CH_D6   = 8'h36;
  localparam logic [7:0] CH_D9   = 8'h39;

  localparam logic [7:0] DNA_N      = 8'd6;
  localparam logic [7:0] DICE_N     = 8'd6;
  localparam logic [7:0] PROTEIN_N  = 8'd21;
  localparam logic [7:0] LETTER_N   = 8'd26;
  localparam logic [7:0] ALNUM_N    = 8'd36;

  typedef struct packed {
    logic [1:0] alphabet;
    logic [7:0] symbol_count;
    logic [3:0] bits_per_symbol;
    logic [4:0] window_order;
    logic       direction;
  } kmsp_cfg_t;

  typedef struct packed {
    logic             has;
    logic [RES_W-1:0] value;
    logic             bad;
    logic             last;
  } kmsp_res_t;

  // shared forward/reverse table: symbol numbers map to characters and back
  function automatic logic [SYM_W-1:0] table_read(input logic [1:0] alpha,
                                                  input logic [7:0] idx);
    logic [7:0] gap;
    logic [7:0] v;
    logic       hit;
    begin
      gap = 8'd0;
      v   = 8'd0;
      hit = 1'b0;
      case (alpha)
        ALPHA_DICE: begin
          if (idx < DICE_N) begin
            v = CH_D1 + idx; hit = 1'b1;
          end else if (idx >= CH_D1 && idx <= CH_D6) begin
            v = idx - CH_D1; hit = 1'b1;
          end
        end
        ALPHA_PROTEIN: begin
          if (idx < PROTEIN_N) begin
            gap = 8'(idx >= 8'd1) + 8'(idx >= 8'd8) + 8'(idx >= 8'd12) + 8'(idx >= 8'd17);
            v   = CH_LC_A + idx + gap;
            hit = 1'b1;
          end else if (idx >= CH_LC_A && idx <= CH_LC_Y && idx != CH_LC_B &&
                       idx != CH_LC_J && idx != CH_LC_O && idx != CH_LC_U) begin
            gap = 8'(idx > CH_LC_B) + 8'(idx > CH_LC_J) + 8'(idx > CH_LC_O) +
                  8'(idx > CH_LC_U);
            v   = idx - CH_LC_A - gap;
            hit = 1'b1;
          end
        end
        ALPHA_ALNUM: begin
          if (idx < LETTER_N) begin
            v = CH_LC_A + idx; hit = 1'b1;
          end else if (idx < ALNUM_N) begin
            v = CH_D0 + (idx - LETTER_N); hit = 1'b1;
          end else if (idx >= CH_LC_A && idx <= CH_LC_Z) begin
            v = idx - CH_LC_A; hit = 1'b1;
          end else if (idx >= CH_D0 && idx <= CH_D9) begin
            v = LETTER_N + (idx - CH_D0); hit = 1'b1;
          end
        end
        default: begin
          hit = 1'b1;
          case (idx)
            8'd0:    v = CH_UC_A;
            8'd1:    v = CH_UC_C;
            8'd2:    v = CH_UC_G;
            8'd3:    v = CH_UC_T;
            8'd4:    v = CH_UC_N;
            8'd5:    v = CH_LC_N;
            CH_UC_A: v = 8'd0;
            CH_UC_C: v = 8'd1;
            CH_UC_G: v = 8'd2;
            CH_UC_T: v = 8'd3;
            CH_UC_N: v = 8'd4;
            CH_LC_N: v = 8'd5;
            default: hit = 1'b0;
          endcase
        end
      endcase
      table_read = hit ? {{(SYM_W-8){1'b0}}, v} : UNMAPPED;
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/core/kmsp_cfg_regs.sv */
// configuration register file of the k-mer symbol packer
`default_nettype none

module kmsp_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             wr_en,
  input  wire logic [kmsp_pkg::CFG_IDX_W-1:0]   wr_index,
  input  wire logic [kmsp_pkg::CFG_DATA_W-1:0]  wr_data,
  output      kmsp_pkg::kmsp_cfg_t              cfg
);
  import kmsp_pkg::*;

  kmsp_cfg_t cfg_r;
  kmsp_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_ALPHABET:  cfg_nxt.alphabet        = wr_data[1:0];
        REG_SYM_COUNT: cfg_nxt.symbol_count    = wr_data[7:0];
        REG_BPS:       cfg_nxt.bits_per_symbol = wr_data[3:0];
        REG_ORDER:     cfg_nxt.window_order    = wr_data[4:0];
        REG_DIRECTION: cfg_nxt.direction       = wr_data[0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alphabet        <= ALPHA_DNA;
      cfg_r.symbol_count    <= 8'd4;
      cfg_r.bits_per_symbol <= 4'd2;
      cfg_r.window_order    <= 5'd1;
      cfg_r.direction       <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* rtl/core/kmsp_core.sv */
// symbol lookup, window shift and sequence state of the k-mer symbol packer
`default_nettype none

module kmsp_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire kmsp_pkg::kmsp_cfg_t          cfg,
  input  wire logic                         fire,
  input  wire logic [kmsp_pkg::SYM_W-1:0]   symbol,
  input  wire logic                         eos,
  output      kmsp_pkg::kmsp_res_t          res
);
  import kmsp_pkg::*;

  logic [CODE_WIDTH-1:0] window_r, window_nxt;
  logic [3:0]            seen_r, seen_nxt;
  logic                  err_r, err_nxt;

  logic [SYM_W-1:0]      sym_mask;
  logic [SYM_W-1:0]      enc_sym;
  logic [SYM_W-1:0]      dec_idx;
  logic [SYM_W-1:0]      dec_val;
  logic [4:0]            order;
  logic [8:0]            total;
  logic [CODE_WIDTH-1:0] wmask;
  logic [CODE_WIDTH-1:0] win_shift;
  logic                  enc_bad;
  logic                  err_upd;
  logic                  emit;

  assign sym_mask = ~({SYM_W{1'b1}} << cfg.bits_per_symbol);

  // encode path
  assign enc_sym = table_read(cfg.alphabet, symbol[7:0]);
  assign order   = (cfg.window_order == 5'd0) ? 5'd1 :
                   (cfg.window_order > 5'd16) ? 5'd16 : cfg.window_order;
  assign total   = 9'(cfg.bits_per_symbol) * 9'(order);
  assign wmask   = (total >= 9'(CODE_WIDTH)) ? {CODE_WIDTH{1'b1}} :
                   ~({CODE_WIDTH{1'b1}} << total);
  assign enc_bad = (enc_sym == UNMAPPED) || (enc_sym >= {8'd0, cfg.symbol_count});
  assign err_upd = err_r | enc_bad;
  assign win_shift = ((window_r << cfg.bits_per_symbol) |
                      CODE_WIDTH'(enc_sym & sym_mask)) & wmask;
  assign emit    = {1'b0, seen_r} >= (order - 5'd1);

  // decode path: masked codes above one byte never hit the table
  assign dec_idx = symbol & sym_mask;
  assign dec_val = (dec_idx[SYM_W-1:8] != '0) ? UNMAPPED :
                   table_read(cfg.alphabet, dec_idx[7:0]);

  always_comb begin
    window_nxt = window_r;
    seen_nxt   = seen_r;
    err_nxt    = err_r;
    res.last   = eos;
    if (cfg.direction) begin
      res.has   = 1'b1;
      res.value = RES_W'(dec_val);
      res.bad   = (dec_val == UNMAPPED);
    end else begin
      res.has   = emit;
      res.value = RES_W'(win_shift);
      res.bad   = err_upd;
      if (eos) begin
        window_nxt = '0;
        seen_nxt   = '0;
        err_nxt    = 1'b0;
      end else begin
        window_nxt = win_shift;
        seen_nxt   = (seen_r == 4'd15) ? seen_r : seen_r + 4'd1;
        err_nxt    = err_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      seen_r   <= '0;
      err_r    <= 1'b0;
    end else if (fire) begin
      window_r <= window_nxt;
      seen_r   <= seen_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/kmer_symbol_packer.sv */
// top level of the k-mer symbol packer: stream ports, input and result stages
`default_nettype none

// Packs a stream of sequence characters into k-mer codes, or maps codes back
// to characters. In encode mode each character (low byte of in_tdata) goes
// through a fixed table for the selected alphabet (DNA ACGTNn, dice 1-6,
// 21 protein letters, 36 alphanumerics) and its symbol number is shifted into
// a window, oldest symbol in the high bits, bits_per_symbol bits per symbol,
// window_order symbols, at most 16 bits. Once window_order symbols of the
// current sequence have arrived, every character gives one code transfer;
// out_tuser carries a sticky flag for unmapped symbols or symbols at or above
// symbol_count. in_tlast ends a sequence and clears window, count and flag;
// a sequence shorter than the order gives no output. In decode mode every
// code gives one character transfer (65535 with out_tuser set if unmapped).
// Throughput is one transfer per clock unless out_tready stalls the result
// register. A result passes through an input stage and a result register,
// with the table lookup and window shift between them. A stalled result holds
// one further input in the input stage before in_tready drops. The user must
// write configuration over the cfg_ channel only while the block is idle; the
// block does not enforce this itself, and cfg_ready is always high.

module kmer_symbol_packer (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input channel
  input  wire logic                             in_tvalid,
  output      logic                             in_tready,
  input  wire logic [15:0]                      in_tdata,   // symbol_in
  input  wire logic                             in_tlast,   // end_of_sequence
  // result channel
  output      logic                             out_tvalid,
  input  wire logic                             out_tready,
  output      logic [15:0]                      out_tdata,  // result_value
  output      logic                             out_tuser,  // bad_symbol_seen
  output      logic                             out_tlast,  // last_of_sequence
  // configuration write channel
  input  wire logic                             cfg_valid,
  output      logic                             cfg_ready,
  input  wire logic [kmsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [kmsp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import kmsp_pkg::*;

  kmsp_cfg_t cfg;
  kmsp_res_t res;

  // input stage
  logic             s1_valid_r;
  logic [SYM_W-1:0] s1_sym_r;
  logic             s1_eos_r;
  logic             s1_go;

  // result stage
  logic             out_valid_r;
  logic [RES_W-1:0] out_data_r;
  logic             out_bad_r;
  logic             out_last_r;

  assign cfg_ready = 1'b1;

  kmsp_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  // the input stage moves on whenever the result register is free or draining;
  // items that produce no result still advance to update the sequence state
  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;

  kmsp_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .fire   (s1_go),
    .symbol (s1_sym_r),
    .eos    (s1_eos_r),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // payload only
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_sym_r <= in_tdata;
      s1_eos_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= res.has;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res.has) begin
      out_data_r <= res.value;
      out_bad_r  <= res.bad;
      out_last_r <= res.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_bad_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire
